// File: src/wsdf_pkg.sv
// wsdf_pkg: types and constants for the websocket frame deframer
// no dependencies; imported by websocket_frame_deframer
`default_nettype none

package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_LEN    = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_UNMASKED = 2'd2
  } status_e;

  localparam logic [7:0]  HDR_FIN_BIT     = 8'h80;
  localparam logic [7:0]  HDR_RSV_BITS    = 8'h70;
  localparam logic [7:0]  HDR_MASK_BIT    = 8'h80;
  localparam logic [7:0]  HDR_LEN7_BITS   = 8'h7f;
  localparam logic [6:0]  LEN_EXT16       = 7'd126;
  localparam logic [6:0]  LEN_EXT64       = 7'd127;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [2:0]  KEY_BYTES       = 3'd4;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'h7FFF;

endpackage

`default_nettype wire

// File: src/websocket_frame_deframer.sv
// websocket_frame_deframer: client-to-server websocket frame parser and unmasker
// depends on wsdf_pkg
//
//   channel  | dir | handshake               | word
//   ---------+-----+-------------------------+-----------------------------------
//   rx       | in  | rx_valid_i / rx_stall_o | rx_byte_i
//   out      | out | out_valid_o/out_stall_i | out_byte_o .. payload_length_o
//   cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_max_payload_i
//
// one received byte per cycle unless rx stalls; unless the parser is closed,
// each byte is decoded in the cycle it is taken and its result, if any, sits
// in the output register from the next cycle on; the rx side stalls only while
// a result is held and the out side stalls; reset clears the parser state,
// max_payload returns to 32767; cfg writes are always taken
`default_nettype none

module websocket_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rx_valid_i,
  output logic             rx_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             frame_end_o,
  output logic             final_flag_o,
  output logic [2:0]       reserved_bits_o,
  output logic [3:0]       frame_opcode_o,
  output logic [1:0]       status_o,
  output logic [63:0]      payload_length_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_max_payload_i
);
  import wsdf_pkg::*;

  phase_e      phase_q, phase_d;
  logic        closed_q, closed_d;
  logic        fin_q, fin_d;
  logic [2:0]  rsv_q, rsv_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [63:0] frame_length_q, frame_length_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [2:0]  key_read_q, key_read_d;
  logic [63:0] payload_count_q, payload_count_d;
  logic        oversize_q, oversize_d;
  logic [15:0] max_payload_q;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        byte_valid_q;
  logic        frame_end_q;
  logic        fin_out_q;
  logic [2:0]  rsv_out_q;
  logic [3:0]  opcode_out_q;
  logic [1:0]  status_q;
  logic [63:0] length_out_q;

  logic        rx_accept;
  logic        res_emit;
  logic [7:0]  res_byte;
  logic        res_byte_valid;
  logic        res_end;
  status_e     res_status;
  logic [63:0] res_length;
  logic        clear_frame;
  logic [6:0]  len7;
  logic [63:0] count_inc;
  logic [7:0]  key_byte;
  logic        last;

  assign rx_stall_o  = out_valid_q & out_stall_i;
  assign rx_accept   = rx_valid_i & ~rx_stall_o;
  assign cfg_ready_o = 1'b1;

  assign len7      = rx_byte_i[6:0] & HDR_LEN7_BITS[6:0];
  assign count_inc = payload_count_q + 64'd1;
  assign last      = (count_inc >= frame_length_q);

  always_comb begin
    case (payload_count_q[1:0])
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d         = phase_q;
    closed_d        = closed_q;
    fin_d           = fin_q;
    rsv_d           = rsv_q;
    opcode_d        = opcode_q;
    frame_length_d  = frame_length_q;
    len_left_d      = len_left_q;
    mask_key_d      = mask_key_q;
    key_read_d      = key_read_q;
    payload_count_d = payload_count_q;
    oversize_d      = oversize_q;
    res_emit        = 1'b0;
    res_byte        = 8'd0;
    res_byte_valid  = 1'b0;
    res_end         = 1'b0;
    res_status      = ST_OK;
    res_length      = 64'd0;
    clear_frame     = 1'b0;

    if (rx_accept && !closed_q) begin
      case (phase_q)
        PH_LEN: begin
          if ((rx_byte_i & HDR_MASK_BIT) == 8'd0) begin
            closed_d   = 1'b1;
            res_emit   = 1'b1;
            res_end    = 1'b1;
            res_status = ST_UNMASKED;
          end else if (len7 == LEN_EXT16) begin
            frame_length_d = 64'd0;
            len_left_d     = EXT16_BYTES;
            phase_d        = PH_EXTLEN;
          end else if (len7 == LEN_EXT64) begin
            frame_length_d = 64'd0;
            len_left_d     = EXT64_BYTES;
            phase_d        = PH_EXTLEN;
          end else begin
            frame_length_d = {57'd0, len7};
            key_read_d     = 3'd0;
            phase_d        = PH_KEY;
          end
        end
        PH_EXTLEN: begin
          frame_length_d = {frame_length_q[55:0], rx_byte_i};
          if (len_left_q != 4'd0) begin
            len_left_d = len_left_q - 4'd1;
          end
          if (len_left_q <= 4'd1) begin
            key_read_d = 3'd0;
            phase_d    = PH_KEY;
          end
        end
        PH_KEY: begin
          mask_key_d = {mask_key_q[23:0], rx_byte_i};
          key_read_d = key_read_q + 3'd1;
          if (key_read_d >= KEY_BYTES) begin
            payload_count_d = 64'd0;
            oversize_d      = (frame_length_q > {48'd0, max_payload_q});
            if (frame_length_q == 64'd0) begin
              res_emit    = 1'b1;
              res_end     = 1'b1;
              clear_frame = 1'b1;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          payload_count_d = count_inc;
          res_length      = frame_length_q;
          if (oversize_q) begin
            if (last) begin
              res_emit    = 1'b1;
              res_end     = 1'b1;
              res_status  = ST_OVERSIZE;
              clear_frame = 1'b1;
            end
          end else begin
            res_emit       = 1'b1;
            res_byte       = rx_byte_i ^ key_byte;
            res_byte_valid = 1'b1;
            res_end        = last;
            clear_frame    = last;
          end
        end
        default: begin
          fin_d           = rx_byte_i[7];
          rsv_d           = 3'((rx_byte_i & HDR_RSV_BITS) >> 4);
          opcode_d        = rx_byte_i[3:0];
          frame_length_d  = 64'd0;
          len_left_d      = 4'd0;
          mask_key_d      = 32'd0;
          key_read_d      = 3'd0;
          payload_count_d = 64'd0;
          oversize_d      = 1'b0;
          phase_d         = PH_LEN;
        end
      endcase

      if (clear_frame) begin
        phase_d         = PH_FIRST;
        fin_d           = 1'b0;
        rsv_d           = 3'd0;
        opcode_d        = 4'd0;
        frame_length_d  = 64'd0;
        len_left_d      = 4'd0;
        mask_key_d      = 32'd0;
        key_read_d      = 3'd0;
        payload_count_d = 64'd0;
        oversize_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_FIRST;
      closed_q        <= 1'b0;
      fin_q           <= 1'b0;
      rsv_q           <= 3'd0;
      opcode_q        <= 4'd0;
      frame_length_q  <= 64'd0;
      len_left_q      <= 4'd0;
      mask_key_q      <= 32'd0;
      key_read_q      <= 3'd0;
      payload_count_q <= 64'd0;
      oversize_q      <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      closed_q        <= closed_d;
      fin_q           <= fin_d;
      rsv_q           <= rsv_d;
      opcode_q        <= opcode_d;
      frame_length_q  <= frame_length_d;
      len_left_q      <= len_left_d;
      mask_key_q      <= mask_key_d;
      key_read_q      <= key_read_d;
      payload_count_q <= payload_count_d;
      oversize_q      <= oversize_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_max_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word, fields taken before the frame state is cleared
  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      out_byte_q   <= res_byte;
      byte_valid_q <= res_byte_valid;
      frame_end_q  <= res_end;
      fin_out_q    <= fin_q;
      rsv_out_q    <= rsv_q;
      opcode_out_q <= opcode_q;
      status_q     <= res_status;
      length_out_q <= res_length;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign byte_valid_o     = byte_valid_q;
  assign frame_end_o      = frame_end_q;
  assign final_flag_o     = fin_out_q;
  assign reserved_bits_o  = rsv_out_q;
  assign frame_opcode_o   = opcode_out_q;
  assign status_o         = status_q;
  assign payload_length_o = length_out_q;

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("parser reopened without reset");

  a_unmasked_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_UNMASKED) |-> closed_q)
    else $error("unmasked status without closing");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !byte_valid_q) |-> frame_end_q)
    else $error("empty result does not end the frame");

  a_data_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (frame_length_q != 64'd0))
    else $error("payload phase with zero length");

endmodule

`default_nettype wire
